@@ rtl/core/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes, types and helper functions of the hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int TABLE_SLOTS = 8;
  localparam int KEY_BYTES   = 8;

  localparam int SLOT_W     = $clog2(TABLE_SLOTS);
  localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int OP_W       = 2;
  localparam int LEN_W      = 4;
  localparam int KEY_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 3;
  localparam int ACTIVE_W   = 4;
  localparam int MARK_W     = 2;
  localparam int ENTRY_W    = LEN_W + KEY_W;
  localparam int HOME_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd3;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOME,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic start_probe;
    logic probe;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stop;
    logic out_free;
  } dp_status_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(KEY_BYTES)) return LEN_W'(KEY_BYTES);
    return len;
  endfunction

  function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] key,
                                                input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (LEN_W'(b) < len) m[8*b +: 8] = key[8*b +: 8];
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] live_slots(input logic [ACTIVE_W-1:0] a);
    if (a == '0) return CNT_W'(1);
    if (HOME_W'(a) > HOME_W'(TABLE_SLOTS)) return CNT_W'(TABLE_SLOTS);
    return CNT_W'(a);
  endfunction

  function automatic logic [SLOT_W-1:0] home_slot(input logic [LEN_W-1:0] len,
                                                  input logic [CNT_W-1:0] n);
    logic [HOME_W-1:0] r;
    logic [HOME_W-1:0] nn;
    r  = HOME_W'(len);
    nn = HOME_W'(n);
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (r >= nn) r = r - nn;
    end
    return SLOT_W'(r);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lpht_req_if.sv @@
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: operation, key length and packed key bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpht_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpht_pkg::OP_W-1:0]   operation;
  logic [lpht_pkg::LEN_W-1:0]  key_length;
  logic [lpht_pkg::KEY_W-1:0]  key_bytes;

  modport source (output valid, output operation, output key_length, output key_bytes,
                  input ready);
  modport sink   (input valid, input operation, input key_length, input key_bytes,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/lpht_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Result channel: status code and slot index.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::INDEX_W-1:0]  slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/lpht_cfg.sv @@
// ----------------------------------------------------------------------------
// lpht_cfg
// APB register slice holding the active slot count.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lpht_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lpht_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [lpht_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                            pready,
  output      logic [lpht_pkg::ACTIVE_W-1:0]   active_slots
);
  import lpht_pkg::*;

  logic                active_sel;
  logic                active_we;
  logic [ACTIVE_W-1:0] active_r;
  logic [ACTIVE_W-1:0] active_nxt;

  assign pready     = 1'b1;
  assign active_sel = (paddr[CFG_ADDR_W-1] == REG_ACTIVE_SLOTS);
  assign active_we  = psel && penable && pwrite && pready && active_sel;
  assign active_nxt = active_we ? pwdata[ACTIVE_W-1:0] : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign prdata       = active_sel ? CFG_DATA_W'(active_r) : '0;
  assign active_slots = active_r;

endmodule

`default_nettype wire

@@ rtl/core/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: take a request, start the probe, walk the slots, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire lpht_pkg::dp_status_t   sts,
  output      lpht_pkg::ctrl_cmd_t    cmd
);
  import lpht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HOME;
      end
      ST_HOME: begin
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.stop) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_HOME: begin
        cmd.start_probe = 1'b1;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        cmd.step  = !sts.stop;
      end
      ST_DONE: begin
        cmd.commit = sts.out_free;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/lpht_dp.sv @@
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: request registers, probe pointer, slot marks, key store and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lpht_pkg::ctrl_cmd_t           cmd,
  output      lpht_pkg::dp_status_t          sts,
  input  wire logic [lpht_pkg::OP_W-1:0]     in_operation,
  input  wire logic [lpht_pkg::LEN_W-1:0]    in_key_length,
  input  wire logic [lpht_pkg::KEY_W-1:0]    in_key_bytes,
  input  wire logic [lpht_pkg::ACTIVE_W-1:0] active_slots,
  input  wire logic                          out_ready,
  output      logic                          out_valid,
  output      logic [lpht_pkg::STATUS_W-1:0] out_status,
  output      logic [lpht_pkg::INDEX_W-1:0]  out_slot_index
);
  import lpht_pkg::*;

  logic [CNT_W-1:0]    n_live;
  logic [CNT_W-1:0]    n_last;
  logic [LEN_W-1:0]    req_len;

  logic [OP_W-1:0]     op_r;
  logic [LEN_W-1:0]    len_r;
  logic [KEY_W-1:0]    key_r;
  logic [SLOT_W-1:0]   ptr_r;
  logic [SLOT_W-1:0]   ptr_nxt;
  logic [SLOT_W-1:0]   cnt_r;
  logic [SLOT_W-1:0]   cnt_nxt;
  logic                free_valid_r;
  logic                free_valid_nxt;
  logic [SLOT_W-1:0]   free_slot_r;
  logic [SLOT_W-1:0]   free_slot_nxt;
  logic                hit_r;
  logic                hit_nxt;

  logic [MARK_W-1:0]   mark_r [TABLE_SLOTS];
  logic [MARK_W-1:0]   cur_mark;
  logic [ENTRY_W-1:0]  rd_entry;
  logic                key_match;
  logic                hit;
  logic                empty;
  logic                last;

  logic                ram_we;
  logic                mark_we;
  logic [SLOT_W-1:0]   mark_waddr;
  logic [MARK_W-1:0]   mark_wdata;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  assign n_live  = live_slots(active_slots);
  assign n_last  = n_live - CNT_W'(1);
  assign req_len = sat_len(in_key_length);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_operation;
      len_r <= req_len;
      key_r <= mask_key(in_key_bytes, req_len);
    end
  end

  assign cur_mark  = mark_r[ptr_r];
  assign key_match = (rd_entry[KEY_W +: LEN_W] == len_r) && (rd_entry[KEY_W-1:0] == key_r);
  assign hit       = (cur_mark == MARK_USED) && key_match;
  assign empty     = (cur_mark == MARK_EMPTY);
  assign last      = (CNT_W'(cnt_r) == n_last);

  assign sts.stop     = hit || empty || last;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    free_valid_nxt = free_valid_r;
    free_slot_nxt  = free_slot_r;
    hit_nxt        = hit_r;
    if (cmd.start_probe) begin
      ptr_nxt        = home_slot(len_r, n_live);
      cnt_nxt        = '0;
      free_valid_nxt = 1'b0;
      hit_nxt        = 1'b0;
    end
    if (cmd.probe) begin
      hit_nxt = hit;
      if (!free_valid_r && (cur_mark != MARK_USED)) begin
        free_valid_nxt = 1'b1;
        free_slot_nxt  = ptr_r;
      end
    end
    if (cmd.step) begin
      ptr_nxt = (ptr_r == n_last[SLOT_W-1:0]) ? '0 : ptr_r + SLOT_W'(1);
      cnt_nxt = cnt_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    free_valid_r <= free_valid_nxt;
    free_slot_r  <= free_slot_nxt;
    hit_r        <= hit_nxt;
  end

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot_r),
    .wdata ({len_r, key_r}),
    .raddr (ptr_nxt),
    .rdata (rd_entry)
  );

  always_comb begin
    ram_we     = 1'b0;
    mark_we    = 1'b0;
    mark_waddr = ptr_r;
    mark_wdata = MARK_USED;
    res_status = STATUS_NOT_FOUND;
    res_slot   = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (hit_r) begin
          res_status = STATUS_PRESENT;
          res_slot   = ptr_r;
        end else if (free_valid_r) begin
          res_status = STATUS_OK;
          res_slot   = free_slot_r;
          ram_we     = cmd.commit;
          mark_we    = cmd.commit;
          mark_waddr = free_slot_r;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      OP_DELETE: begin
        if (hit_r) begin
          res_status = STATUS_OK;
          res_slot   = ptr_r;
          mark_we    = cmd.commit;
          mark_wdata = MARK_GONE;
        end
      end
      default: begin
        if (hit_r) begin
          res_status = STATUS_OK;
          res_slot   = ptr_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        mark_r[s] <= MARK_EMPTY;
      end
    end else if (mark_we) begin
      mark_r[mark_waddr] <= mark_wdata;
    end
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = INDEX_W'(out_slot_r);

  a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over an untaken result");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (CNT_W'(ptr_r) < n_live))
    else $error("probe pointer beyond active slots");

  a_hit_is_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && hit_r) |-> (cur_mark == MARK_USED))
    else $error("match reported on a slot that is not occupied");

  a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == OP_INSERT) && !hit_r && free_valid_r)
      |=> (mark_r[$past(free_slot_r)] == MARK_USED))
    else $error("filled slot not marked occupied");

endmodule

`default_nettype wire

@@ rtl/core/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key table with linear probing: search, insert, delete.
//
// in_req carries one request per transfer (operation, key_length, key_bytes);
// out_rsp returns one result per request (status, slot_index), in order.
// The cfg_ APB port holds active_slots at byte address 0; a write lands on
// the edge with psel, penable, pwrite and pready high, pready is tied high.
// A request is taken only while the sequencer is idle. It forms the home
// slot in ST_HOME, then probes the slots in turn in ST_PROBE through the key
// RAM read port, up to the active slot count, then commits in ST_DONE, which
// registers the result. Insert finds its free slot during the same walk.
// A result waiting in the output register does not block the next request;
// only the commit of the following result waits for out_rsp to drain.
// Reset marks every slot empty and sets active_slots to 8; the key RAM
// needs no clearing since only occupied slots are compared.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lpht_req_if.sink                             in_req,
  lpht_rsp_if.source                           out_rsp,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lpht_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lpht_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [lpht_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);
  import lpht_pkg::*;

  logic [ACTIVE_W-1:0] active_slots;
  ctrl_cmd_t           cmd;
  dp_status_t          sts;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_slot_index;

  lpht_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .active_slots (active_slots)
  );

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_req.operation),
    .in_key_length  (in_req.key_length),
    .in_key_bytes   (in_req.key_bytes),
    .active_slots   (active_slots),
    .out_ready      (out_rsp.ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_valid;
  assign out_rsp.status     = out_status;
  assign out_rsp.slot_index = out_slot_index;

endmodule

`default_nettype wire
